>>> sv/tcp_syn_header_builder_assert.svh
// assertion macros for the syn header builder checker
`ifndef TCP_SYN_HEADER_BUILDER_ASSERT_SVH
`define TCP_SYN_HEADER_BUILDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TSH_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst is high
`define TSH_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tsh_pkg.sv
// shared types, constants and checksum helper for the syn header builder
`default_nettype none

package tsh_pkg;

  localparam int unsigned HDR_WORDS = 20;
  localparam int unsigned IDX_W     = 5;
  localparam logic [IDX_W-1:0] LAST_IDX = 5'd19;

  // fixed header words
  localparam logic [15:0] IP_VER_WORD    = 16'h4500;
  localparam logic [15:0] IP_TOTAL_LEN   = 16'd40;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [15:0] TCP_LEN        = 16'd20;
  localparam logic [15:0] TCP_FLAGS_WORD = 16'h5002;

  // register file
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_TTL    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 8'd1;
  localparam logic [7:0]  TTL_RESET    = 8'd64;
  localparam logic [15:0] WINDOW_RESET = 16'd8192;

  typedef struct packed {
    logic [31:0] seq_number;
    logic [15:0] ip_ident;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dest_addr;
    logic [31:0] source_addr;
  } req_t;

  // fold a 20-bit sum to 16 bits with end-around carry and invert
  function automatic logic [15:0] fold_invert(input logic [19:0] s);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = 17'(s[15:0]) + 17'(s[19:16]);
    f2 = f1[15:0] + 16'(f1[16]);
    return ~f2;
  endfunction

endpackage

`default_nettype wire

>>> sv/tcp_syn_header_builder.sv
// top level: ipv4 + tcp syn header builder with checksum pipeline and word serializer
`default_nettype none

// usage
//   s_axis carries one probe request per item (addresses, ports, ident, seq number).
//   m_axis returns the 40-byte ipv4 + tcp syn header as twenty 16-bit words,
//   word 0 first, each tagged with its position; tlast marks word 19.
//   cfg writes time_to_live (index 0) and window_size (index 1); other indexes are
//   ignored. cfg_ready is always high; write only while no request is in flight.
// pipeline and throughput
//   three register stages build the sums and checksums; an accepted request passes
//   through stages 1, 2 and 3 and is loaded into the serializer when it is empty or
//   while its last word leaves. the serializer sends one word per cycle while
//   m_axis_tready is high.
//   up to three further requests wait in the stages while a header is sent.
// reset
//   rst (synchronous) empties all stages and the serializer and loads ttl 64 and
//   window 8192.
// stall
//   while m_axis_tready is low the current word holds; the stages fill and then
//   s_axis_tready drops. nothing is lost or sent twice.
module tcp_syn_header_builder (
  input  wire logic         clk,
  input  wire logic         rst,
  // request in
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // source_addr[31:0], dest_addr[63:32], src_port[79:64], dst_port[95:80],
  // ip_ident[111:96], seq_number[143:112]
  input  wire logic [143:0] s_axis_tdata,
  // header words out
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // header_word[15:0], word_index[20:16], zero[23:21]
  output logic [23:0]       m_axis_tdata,
  output logic              m_axis_tlast,
  // register writes
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [tsh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]  cfg_data
);

  // configuration registers
  logic [7:0]  ttl;
  logic [15:0] window;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ttl    <= tsh_pkg::TTL_RESET;
      window <= tsh_pkg::WINDOW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        tsh_pkg::REG_TTL:    ttl    <= cfg_data[7:0];
        tsh_pkg::REG_WINDOW: window <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the request
  tsh_pkg::req_t in_req;
  always_comb begin
    in_req.source_addr = s_axis_tdata[31:0];
    in_req.dest_addr   = s_axis_tdata[63:32];
    in_req.src_port    = s_axis_tdata[79:64];
    in_req.dst_port    = s_axis_tdata[95:80];
    in_req.ip_ident    = s_axis_tdata[111:96];
    in_req.seq_number  = s_axis_tdata[143:112];
  end

  // stage registers
  logic          s1_valid, s2_valid, s3_valid;
  tsh_pkg::req_t s1_req, s2_req, s3_req;
  logic [17:0]   s1_addr_sum, s1_ip_misc, s1_tcp_misc, s1_tcp_const;
  logic [18:0]   s2_ip_sum;
  logic [19:0]   s2_tcp_sum;
  logic [15:0]   s3_ip_csum, s3_tcp_csum;

  // serializer
  logic                      out_valid;
  logic [tsh_pkg::IDX_W-1:0] out_idx;
  logic [15:0]               words [tsh_pkg::HDR_WORDS];
  logic [15:0]               hdr   [tsh_pkg::HDR_WORDS];

  logic take, out_last, load, ready3, ready2, ready1;

  assign take     = out_valid && m_axis_tready;
  assign out_last = (out_idx == tsh_pkg::LAST_IDX);
  // serializer takes a new header when empty or while its last word leaves
  assign load     = s3_valid && (!out_valid || (take && out_last));
  assign ready3   = !s3_valid || load;
  assign ready2   = !s2_valid || ready3;
  assign ready1   = !s1_valid || ready2;
  assign s_axis_tready = ready1;

  // stage 1: partial sums of 16-bit words
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ready1) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && s_axis_tvalid) begin
      s1_req       <= in_req;
      s1_addr_sum  <= 18'(in_req.source_addr[31:16]) + 18'(in_req.source_addr[15:0])
                    + 18'(in_req.dest_addr[31:16]) + 18'(in_req.dest_addr[15:0]);
      s1_ip_misc   <= 18'(in_req.ip_ident) + 18'({ttl, tsh_pkg::PROTO_TCP})
                    + 18'(tsh_pkg::IP_VER_WORD) + 18'(tsh_pkg::IP_TOTAL_LEN);
      s1_tcp_misc  <= 18'(in_req.src_port) + 18'(in_req.dst_port)
                    + 18'(in_req.seq_number[31:16]) + 18'(in_req.seq_number[15:0]);
      // window, flags word and the constant part of the pseudo-header
      s1_tcp_const <= 18'(window) + 18'(tsh_pkg::TCP_FLAGS_WORD)
                    + 18'(tsh_pkg::PROTO_TCP) + 18'(tsh_pkg::TCP_LEN);
    end
  end

  // stage 2: full ip and tcp sums (addresses count in both)
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ready2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2 && s1_valid) begin
      s2_req     <= s1_req;
      s2_ip_sum  <= 19'(s1_addr_sum) + 19'(s1_ip_misc);
      s2_tcp_sum <= 20'(s1_addr_sum) + 20'(s1_tcp_misc) + 20'(s1_tcp_const);
    end
  end

  // stage 3: fold and invert
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ready3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && s2_valid) begin
      s3_req      <= s2_req;
      s3_ip_csum  <= tsh_pkg::fold_invert(20'(s2_ip_sum));
      s3_tcp_csum <= tsh_pkg::fold_invert(s2_tcp_sum);
    end
  end

  // header image from stage 3
  always_comb begin
    hdr[0]  = tsh_pkg::IP_VER_WORD;
    hdr[1]  = tsh_pkg::IP_TOTAL_LEN;
    hdr[2]  = s3_req.ip_ident;
    hdr[3]  = 16'h0000;
    hdr[4]  = {ttl, tsh_pkg::PROTO_TCP};
    hdr[5]  = s3_ip_csum;
    hdr[6]  = s3_req.source_addr[31:16];
    hdr[7]  = s3_req.source_addr[15:0];
    hdr[8]  = s3_req.dest_addr[31:16];
    hdr[9]  = s3_req.dest_addr[15:0];
    hdr[10] = s3_req.src_port;
    hdr[11] = s3_req.dst_port;
    hdr[12] = s3_req.seq_number[31:16];
    hdr[13] = s3_req.seq_number[15:0];
    hdr[14] = 16'h0000;
    hdr[15] = 16'h0000;
    hdr[16] = tsh_pkg::TCP_FLAGS_WORD;
    hdr[17] = window;
    hdr[18] = s3_tcp_csum;
    hdr[19] = 16'h0000;
  end

  // serializer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_idx   <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      out_idx   <= '0;
    end else if (take) begin
      if (out_last) begin
        out_valid <= 1'b0;
      end else begin
        out_idx <= out_idx + 5'd1;
      end
    end
  end

  // serializer words: load the image, then shift toward word 0
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < tsh_pkg::HDR_WORDS; i++) begin
        words[i] <= hdr[i];
      end
    end else if (take) begin
      for (int i = 0; i < tsh_pkg::HDR_WORDS - 1; i++) begin
        words[i] <= words[i+1];
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_idx, words[0]};
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

>>> sv/tsh_checker.sv
// port-level checker for the syn header builder, bound to the top level
`default_nettype none

`include "tcp_syn_header_builder_assert.svh"

module tsh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic [tsh_pkg::IDX_W-1:0] idx;
  assign idx = m_axis_tdata[20:16];

  `TSH_ASSERT_IMP(a_last_at_end, m_axis_tvalid, m_axis_tlast == (idx == tsh_pkg::LAST_IDX), "tlast not on word 19")
  `TSH_ASSERT_NXT(a_idx_steps, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && (idx == $past(idx) + 5'd1), "word index did not advance by one")
  `TSH_ASSERT_IMP(a_first_word, m_axis_tvalid && (idx == '0), m_axis_tdata[15:0] == tsh_pkg::IP_VER_WORD, "word 0 is not version and ihl")
  `TSH_ASSERT_NXT(a_hold_on_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")

endmodule

bind tcp_syn_header_builder tsh_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

>>> sim/tcp_syn_header_builder_tb.sv
// self-checking testbench for the ipv4 + tcp syn header builder
`timescale 1ns / 1ps

module tcp_syn_header_builder_tb;

  // register indexes past the end of the register file, writes there must be ignored
  localparam logic [tsh_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam logic [tsh_pkg::CFG_IDX_W-1:0] REG_TOP    = 8'hFF;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  // pipeline is three stages deep, let it settle before touching registers
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned ITEMS_PER_PHASE = 39;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef logic [tsh_pkg::HDR_WORDS-1:0][15:0] header_words_t;

  // one output word as it should appear on m_axis
  typedef struct packed {
    logic [15:0]               word;
    logic [tsh_pkg::IDX_W-1:0] index;
    logic                      last;
  } header_beat_t;

  typedef enum logic {STEP_PROBE, STEP_REG} step_kind_t;

  // directed stimulus row: either a probe request or a register write
  typedef struct packed {
    step_kind_t                    kind;
    tsh_pkg::req_t                 probe;
    logic [tsh_pkg::CFG_IDX_W-1:0] reg_index;
    logic [15:0]                   reg_value;
    logic                          known;     // checksums below typed in by hand
    logic [15:0]                   ip_csum;
    logic [15:0]                   tcp_csum;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [tsh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [15:0]                   cfg_data;

  // current register contents as the builder should hold them
  logic [7:0]  model_ttl    = tsh_pkg::TTL_RESET;
  logic [15:0] model_window = tsh_pkg::WINDOW_RESET;

  header_beat_t pending_beats[$];
  step_t        directed_steps[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  tcp_syn_header_builder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  // ones-complement checksum: fold carries back in until 16 bits remain, then invert
  function automatic logic [15:0] internet_checksum(input logic [31:0] acc);
    logic [31:0] s;
    s = acc;
    while (s[31:16] != 16'd0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
    return ~s[15:0];
  endfunction

  // the full 40-byte header for one probe under the given ttl and window
  function automatic header_words_t build_syn_header(input tsh_pkg::req_t p,
                                                     input logic [7:0] ttl,
                                                     input logic [15:0] window);
    header_words_t w;
    logic [31:0]   acc;
    int            i;
    w      = '0;
    w[0]   = tsh_pkg::IP_VER_WORD;
    w[1]   = tsh_pkg::IP_TOTAL_LEN;
    w[2]   = p.ip_ident;
    w[4]   = {ttl, tsh_pkg::PROTO_TCP};
    w[6]   = p.source_addr[31:16];
    w[7]   = p.source_addr[15:0];
    w[8]   = p.dest_addr[31:16];
    w[9]   = p.dest_addr[15:0];
    w[10]  = p.src_port;
    w[11]  = p.dst_port;
    w[12]  = p.seq_number[31:16];
    w[13]  = p.seq_number[15:0];
    w[16]  = tsh_pkg::TCP_FLAGS_WORD;
    w[17]  = window;
    // ip checksum over the ten ip words with the check field still zero
    acc = 32'd0;
    for (i = 0; i < 10; i++) acc += {16'd0, w[i]};
    w[5] = internet_checksum(acc);
    // tcp checksum: pseudo-header plus the tcp header with its check field zero
    acc = {16'd0, w[6]} + {16'd0, w[7]} + {16'd0, w[8]} + {16'd0, w[9]}
        + {24'd0, tsh_pkg::PROTO_TCP} + {16'd0, tsh_pkg::TCP_LEN};
    for (i = 10; i < tsh_pkg::HDR_WORDS; i++) acc += {16'd0, w[i]};
    w[18] = internet_checksum(acc);
    return w;
  endfunction

  function automatic tsh_pkg::req_t make_probe(input logic [31:0] src, input logic [31:0] dst,
                                               input logic [31:0] sport,
                                               input logic [31:0] dport,
                                               input logic [31:0] ident,
                                               input logic [31:0] seq);
    tsh_pkg::req_t p;
    p.source_addr = src;
    p.dest_addr   = dst;
    p.src_port    = sport[15:0];
    p.dst_port    = dport[15:0];
    p.ip_ident    = ident[15:0];
    p.seq_number  = seq;
    return p;
  endfunction

  function automatic step_t probe_step(input tsh_pkg::req_t p, input logic known,
                                       input logic [15:0] ip_c, input logic [15:0] tcp_c);
    step_t st;
    st           = '0;
    st.kind      = STEP_PROBE;
    st.probe     = p;
    st.known     = known;
    st.ip_csum   = ip_c;
    st.tcp_csum  = tcp_c;
    return st;
  endfunction

  function automatic step_t reg_step(input logic [tsh_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [15:0] val);
    step_t st;
    st           = '0;
    st.kind      = STEP_REG;
    st.reg_index = idx;
    st.reg_value = val;
    return st;
  endfunction

  // field value biased toward the all-zero and all-one corners
  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // queue the twenty words this probe must produce
  task automatic queue_header(input tsh_pkg::req_t p, input logic known,
                              input logic [15:0] ip_c, input logic [15:0] tcp_c);
    header_words_t w;
    header_beat_t  b;
    int            i;
    w = build_syn_header(p, model_ttl, model_window);
    if (known) begin
      w[5]  = ip_c;
      w[18] = tcp_c;
    end
    for (i = 0; i < tsh_pkg::HDR_WORDS; i++) begin
      b.word  = w[i];
      b.index = i[tsh_pkg::IDX_W-1:0];
      b.last  = (b.index == tsh_pkg::LAST_IDX);
      pending_beats.push_back(b);
    end
  endtask

  // hand one probe to the builder, starting and ending at a falling edge
  task automatic send_probe(input tsh_pkg::req_t p, input logic known,
                            input logic [15:0] ip_c, input logic [15:0] tcp_c);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    queue_header(p, known, ip_c, tcp_c);
    @(negedge clk);
  endtask

  // stop sending and wait until every queued word has come back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
  endtask

  // register write, only once the builder has gone quiet
  task automatic write_register(input logic [tsh_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] val);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tsh_pkg::REG_TTL) model_ttl = val[7:0];
    else if (idx == tsh_pkg::REG_WINDOW) model_window = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("mismatch in %s at %0t: expected %h, got %h", field, $realtime, want, got);
  endtask

  // receiver side: stall at random according to the current phase
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // compare each accepted header word with the oldest queued one
  always @(posedge clk) begin : check_words
    header_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        flag_mismatch("unexpected header word", 32'd0, {8'd0, m_axis_tdata});
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tdata[15:0] !== want.word)
          flag_mismatch("header_word", 32'(want.word), 32'(m_axis_tdata[15:0]));
        if (m_axis_tdata[20:16] !== want.index)
          flag_mismatch("word_index", 32'(want.index), 32'(m_axis_tdata[20:16]));
        if (m_axis_tlast !== want.last)
          flag_mismatch("last_word", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    step_t         st;
    tsh_pkg::req_t p;
    int unsigned   phase;
    int unsigned   n;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;

    // directed rows; hand-typed checksums hold only for ttl 64 and window 8192
    // all-zero probe right after reset
    directed_steps.push_back(probe_step(make_probe(0, 0, 0, 0, 0, 0), 1'b1,
                                        16'h7AD1, 16'h8FE3));
    // all-ones probe, identification 65535 included; ffff words add nothing
    directed_steps.push_back(probe_step(make_probe(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF,
                                                   32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF),
                                        1'b1, 16'h7AD1, 16'h8FE3));
    // both sums fold to ffff, so both checksums go out as zero
    directed_steps.push_back(probe_step(make_probe(0, 0, 32'h8FE3, 0, 32'h7AD1, 0), 1'b1,
                                        16'h0000, 16'h0000));
    directed_steps.push_back(probe_step(make_probe(32'hC0A8_0001, 32'h0A00_0002, 12345, 80,
                                                   32'h1234, 32'h0123_4567), 1'b0, 0, 0));
    directed_steps.push_back(probe_step(make_probe(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA,
                                                   32'h5555, 32'hAAAA, 32'h5555_5555),
                                        1'b0, 0, 0));
    directed_steps.push_back(probe_step(make_probe(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555,
                                                   32'hAAAA, 32'h5555, 32'hAAAA_AAAA),
                                        1'b0, 0, 0));
    // low extremes of both registers
    directed_steps.push_back(reg_step(tsh_pkg::REG_TTL, 16'h0000));
    directed_steps.push_back(reg_step(tsh_pkg::REG_WINDOW, 16'h0000));
    directed_steps.push_back(probe_step(make_probe(0, 0, 0, 0, 0, 0), 1'b0, 0, 0));
    directed_steps.push_back(probe_step(make_probe(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF,
                                                   32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF),
                                        1'b0, 0, 0));
    directed_steps.push_back(probe_step(make_probe(32'h7F00_0001, 32'h0808_0808, 1, 65535,
                                                   32'hFFFE, 32'h8000_0000), 1'b0, 0, 0));
    // high extremes; upper byte of the ttl write must be dropped
    directed_steps.push_back(reg_step(tsh_pkg::REG_TTL, 16'hABFF));
    directed_steps.push_back(reg_step(tsh_pkg::REG_WINDOW, 16'hFFFF));
    directed_steps.push_back(probe_step(make_probe(0, 0, 0, 0, 0, 0), 1'b0, 0, 0));
    directed_steps.push_back(probe_step(make_probe(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF,
                                                   32'hFFFF, 32'hFFFF, 32'hFFFF_FFFF),
                                        1'b0, 0, 0));
    directed_steps.push_back(probe_step(make_probe(32'hDEAD_BEEF, 32'h0123_4567, 443, 22,
                                                   32'h0042, 32'hFFFF_0000), 1'b0, 0, 0));
    // writes past the register file change nothing
    directed_steps.push_back(reg_step(REG_UNUSED, 16'h1234));
    directed_steps.push_back(reg_step(REG_TOP, 16'hFFFF));
    directed_steps.push_back(probe_step(make_probe(32'h0A0B_0C0D, 32'hF0E0_D0C0, 8080, 53,
                                                   32'h8001, 32'h0000_FFFF), 1'b0, 0, 0));
    // back to the reset values, hand-typed checksums valid again
    directed_steps.push_back(reg_step(tsh_pkg::REG_TTL, 16'd64));
    directed_steps.push_back(reg_step(tsh_pkg::REG_WINDOW, 16'd8192));
    directed_steps.push_back(probe_step(make_probe(0, 0, 0, 0, 0, 0), 1'b1,
                                        16'h7AD1, 16'h8FE3));

    // hold reset, then release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_steps[i]) begin
      st = directed_steps[i];
      case (st.kind)
        STEP_PROBE: begin
          send_probe(st.probe, st.known, st.ip_csum, st.tcp_csum);
        end
        STEP_REG: begin
          write_register(st.reg_index, st.reg_value);
        end
        default: ;
      endcase
    end

    // random phases: free running, sender idle, receiver stalling, both
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase

      // fresh register settings for each phase, corners now and then
      if ($urandom_range(0, 2) == 0) write_register(REG_UNUSED + 8'($urandom_range(0, 253)),
                                                    16'($urandom));
      case ($urandom_range(0, 3))
        0:       write_register(tsh_pkg::REG_TTL, 16'h0000);
        1:       write_register(tsh_pkg::REG_TTL, 16'h00FF);
        default: write_register(tsh_pkg::REG_TTL, 16'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0:       write_register(tsh_pkg::REG_WINDOW, 16'h0000);
        1:       write_register(tsh_pkg::REG_WINDOW, 16'hFFFF);
        default: write_register(tsh_pkg::REG_WINDOW, 16'($urandom));
      endcase

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender holds back once until the pipeline has fully emptied
        if (phase == 1 && n == ITEMS_PER_PHASE / 2) wait_for_drain();
        p = make_probe(pick_field(), pick_field(), pick_field(), pick_field(),
                       pick_field(), pick_field());
        send_probe(p, 1'b0, 16'd0, 16'd0);
      end
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    wait_for_drain();
    // anything extra that shows up now is caught by the checker
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
